@@ rtl/fffa_pkg.sv @@
// Shared types, constants and helpers of the fair reader/writer arbiter.
package fffa_pkg;

  localparam int QueueDepth = 16;
  localparam int IdBits     = 6;
  localparam int MaxResults = 16;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int NumW       = $clog2(MaxResults + 1);
  localparam int ReadersW   = 7;
  localparam int EntryW     = IdBits + 1;
  localparam int SlotW      = 1;
  localparam int SlotCntW   = SlotW + 1;
  localparam int Slots      = 2;

  localparam logic [1:0] OpStartRead  = 2'd0;
  localparam logic [1:0] OpEndRead    = 2'd1;
  localparam logic [1:0] OpStartWrite = 2'd2;
  localparam logic [1:0] OpEndWrite   = 2'd3;

  localparam logic [1:0] StGrant    = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNoHolder = 2'd2;

  typedef struct packed {
    logic              start;
    logic              write;
    logic [IdBits-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic [IdBits-1:0] id;
    logic              write;
    logic [1:0]        status;
    logic              last;
  } res_t;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(QueueDepth - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

@@ rtl/fffa_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
module fffa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fffa_front.sv @@
// Front end: accepts requests, classifies them and queues them as commands.
module fffa_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  op_i,
  input  logic [fffa_pkg::IdBits-1:0] requester_id_i,
  output logic                        cmd_valid_o,
  output fffa_pkg::cmd_t              cmd_o,
  input  logic                        cmd_pop_i
);
  import fffa_pkg::*;

  cmd_t               slot_q [Slots];
  logic [SlotW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [SlotCntW-1:0] cnt_q, cnt_d;
  cmd_t               cmd_in;
  logic               do_push, do_pop;

  always_comb begin
    cmd_in.id = requester_id_i;
    case (op_i)
      OpStartRead: begin
        cmd_in.start = 1'b1;
        cmd_in.write = 1'b0;
      end
      OpEndRead: begin
        cmd_in.start = 1'b0;
        cmd_in.write = 1'b0;
      end
      OpStartWrite: begin
        cmd_in.start = 1'b1;
        cmd_in.write = 1'b1;
      end
      default: begin
        cmd_in.start = 1'b0;
        cmd_in.write = 1'b1;
      end
    endcase
  end

  assign full        = (cnt_q == SlotCntW'(Slots));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + SlotCntW'(do_push) - SlotCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/fffa_outq.sv @@
// Result queue: holds finished result words until the receiver pops them.
module fffa_outq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        res_push_i,
  input  fffa_pkg::res_t              res_i,
  output logic                        res_full_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [fffa_pkg::IdBits-1:0] grant_id_o,
  output logic                        grant_write_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);
  import fffa_pkg::*;

  res_t                slot_q [Slots];
  logic [SlotW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [SlotCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;
  res_t                head;

  assign res_full_o = (cnt_q == SlotCntW'(Slots));
  assign empty      = (cnt_q == '0);
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;
  assign head       = slot_q[rd_q];

  assign grant_id_o    = head.id;
  assign grant_write_o = head.write;
  assign status_o      = head.status;
  assign last_o        = head.last;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + SlotCntW'(do_push) - SlotCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/fffa_back.sv @@
// Back end: owns the holder counts and the wait queue and produces results.
module fffa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  fffa_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           res_push_o,
  output fffa_pkg::res_t res_o,
  input  logic           res_full_i
);
  import fffa_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SWake = 2'd1;
  localparam logic [1:0] SRead = 2'd2;
  localparam logic [1:0] SLast = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [IdxW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [ReadersW-1:0] readers_q, readers_d;
  logic                writer_q, writer_d;
  logic [NumW-1:0]     num_q, num_d;
  logic [IdBits-1:0]   pend_q, pend_d;

  logic                ram_we, ram_re;
  logic [IdxW-1:0]     ram_raddr;
  logic [EntryW-1:0]   ram_wdata, ram_rdata;
  logic [IdxW-1:0]     head_next;

  fffa_ram #(
    .Width(EntryW),
    .Depth(QueueDepth)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign head_next = idx_inc(head_q);
  assign ram_wdata = {cmd_i.write, cmd_i.id};

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    readers_d  = readers_q;
    writer_d   = writer_q;
    num_d      = num_q;
    pend_d     = pend_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = head_q;
    case (state_q)
      SIdle: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o   = 1'b1;
          num_d       = '0;
          res_o.id    = cmd_i.id;
          res_o.write = cmd_i.write;
          res_o.last  = 1'b1;
          if (cmd_i.start) begin
            if (count_q == '0 && !writer_q && readers_q == '0) begin
              if (cmd_i.write) begin
                writer_d = 1'b1;
              end else begin
                readers_d = ReadersW'(1);
              end
              res_o.status = StGrant;
              res_push_o   = 1'b1;
            end else if (count_q == CntW'(QueueDepth)) begin
              res_o.status = StFull;
              res_push_o   = 1'b1;
            end else begin
              ram_we  = 1'b1;
              tail_d  = idx_inc(tail_q);
              count_d = count_q + 1'b1;
            end
          end else if (!cmd_i.write) begin
            if (readers_q == '0) begin
              res_o.status = StNoHolder;
              res_push_o   = 1'b1;
            end else begin
              readers_d = readers_q - 1'b1;
              if (readers_q == ReadersW'(1)) begin
                state_d = SWake;
              end
            end
          end else begin
            if (!writer_q) begin
              res_o.status = StNoHolder;
              res_push_o   = 1'b1;
            end else begin
              writer_d = 1'b0;
              state_d  = SWake;
            end
          end
        end
      end
      SWake: begin
        if (count_q == '0) begin
          state_d = SIdle;
        end else begin
          ram_re  = 1'b1;
          state_d = SRead;
        end
      end
      SRead: begin
        if (!res_full_i) begin
          res_o.status = StGrant;
          if (ram_rdata[EntryW-1]) begin
            res_push_o = 1'b1;
            res_o.last = 1'b1;
            state_d    = SIdle;
            if (num_q == '0) begin
              res_o.id    = ram_rdata[IdBits-1:0];
              res_o.write = 1'b1;
              writer_d    = 1'b1;
              head_d      = head_next;
              count_d     = count_q - 1'b1;
            end else begin
              res_o.id = pend_q;
            end
          end else begin
            res_o.id   = pend_q;
            res_push_o = (num_q != '0);
            pend_d     = ram_rdata[IdBits-1:0];
            head_d     = head_next;
            count_d    = count_q - 1'b1;
            readers_d  = readers_q + 1'b1;
            num_d      = num_q + 1'b1;
            if (num_q == NumW'(MaxResults - 1) || count_q == CntW'(1)) begin
              state_d = SLast;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_next;
            end
          end
        end
      end
      SLast: begin
        if (!res_full_i) begin
          res_o.id     = pend_q;
          res_o.status = StGrant;
          res_o.last   = 1'b1;
          res_push_o   = 1'b1;
          state_d      = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      readers_q <= '0;
      writer_q  <= 1'b0;
      num_q     <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      readers_q <= readers_d;
      writer_q  <= writer_d;
      num_q     <= num_d;
    end
  end

endmodule

@@ rtl/fifo_fair_reader_writer_arbiter_top.sv @@
// Top level of the fair reader/writer arbiter.
//
// Requests enter through a queue-style port: a word (op_i, requester_id_i) is
// taken when push is high and full is low. Results leave the same way: the
// oldest result word is shown while empty is low and is taken when pop is high.
// A start request is granted at once only when nobody holds the resource and
// nobody waits; otherwise it waits in a sixteen-entry ring in arrival order, and
// a full ring rejects it. A release by the last reader or by the writer serves
// the head: one writer, or a run of up to sixteen readers with the final grant
// marked by last_o. A release with no holder returns an error word.
// A request is registered in the two-entry front queue and decided by the back end
// once it heads that queue, the back end is idle and the result queue has room;
// its result word is registered in the result queue and shown while empty is low.
// A release that wakes a waiting writer grants it after the wake and ring-read
// states. A reader run first reads the ring through its registered read port and
// then gives one grant per cycle while the result queue has room.
// Reset clears the holder counts, the ring pointers and both small queues; no
// clearing pass is needed. When the receiver stalls, the result queue fills,
// the decision logic waits, and full rises once the two-entry front queue fills.
module fifo_fair_reader_writer_arbiter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  op_i,
  input  logic [fffa_pkg::IdBits-1:0] requester_id_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [fffa_pkg::IdBits-1:0] grant_id_o,
  output logic                        grant_write_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);
  import fffa_pkg::*;

  logic cmd_valid, cmd_pop, res_push, res_full;
  cmd_t cmd;
  res_t res;

  fffa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .requester_id_i(requester_id_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  fffa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (res),
    .res_full_i (res_full)
  );

  fffa_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_push_i   (res_push),
    .res_i        (res),
    .res_full_o   (res_full),
    .empty        (empty),
    .pop          (pop),
    .grant_id_o   (grant_id_o),
    .grant_write_o(grant_write_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != StGrant) |-> last_o)
    else $error("A rejected or erroneous word is not marked last.");

  a_write_grant_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == StGrant && grant_write_o) |-> last_o)
    else $error("A write grant is not the only word of its request.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == StGrant || status_o == StFull || status_o == StNoHolder))
    else $error("A result word carries an unknown status code.");

  a_push_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_full) |-> 1'b0)
    else $error("The back end pushed a result into a full result queue.");

endmodule

@@ tb/fifo_fair_reader_writer_arbiter_checker.sv @@
// Checker that predicts the result words of the fair reader/writer arbiter and compares them.
module fifo_fair_reader_writer_arbiter_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  logic                        full,
  input  logic [1:0]                  op_i,
  input  logic [fffa_pkg::IdBits-1:0] requester_id_i,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [fffa_pkg::IdBits-1:0] grant_id_o,
  input  logic                        grant_write_o,
  input  logic [1:0]                  status_o,
  input  logic                        last_o,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          grants_seen_o,
  output int                          full_seen_o,
  output int                          no_holder_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fffa_pkg::*;

  typedef struct packed {
    logic              wr;
    logic [IdBits-1:0] id;
  } waiter_t;

  waiter_t               ring [QueueDepth];
  logic [IdxW-1:0]       head;
  logic [IdxW-1:0]       tail;
  logic [CntW-1:0]       count;
  logic [ReadersW-1:0]   readers;
  logic                  writer;
  res_t                  expected_grants[$];
  res_t                  batch[$];
  int                    words_checked;

  task automatic report_mismatch(input string what);
    if (fail_count_o < 50) $display("%0t: MISMATCH %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic add_word(input logic [IdBits-1:0] id, input logic wr, input logic [1:0] st);
    res_t w;
    w.id     = id;
    w.write  = wr;
    w.status = st;
    w.last   = 1'b0;
    batch.push_back(w);
  endtask

  task automatic take_head(output waiter_t w);
    w     = ring[head];
    head  = IdxW'((int'(head) + 1) % QueueDepth);
    count = count - 1'b1;
  endtask

  task automatic serve_waiters();
    waiter_t w;
    int      n;
    n = 0;
    if (count != 0) begin
      if (ring[head].wr) begin
        take_head(w);
        writer = 1'b1;
        add_word(w.id, 1'b1, StGrant);
      end else begin
        while (n < MaxResults && count != 0 && !ring[head].wr) begin
          take_head(w);
          readers = readers + 1'b1;
          add_word(w.id, 1'b0, StGrant);
          n++;
        end
      end
    end
  endtask

  task automatic request_start(input logic [IdBits-1:0] id, input logic wr);
    waiter_t w;
    if (count == 0 && !writer && readers == 0) begin
      if (wr) writer = 1'b1;
      else readers = ReadersW'(1);
      add_word(id, wr, StGrant);
    end else if (count >= CntW'(QueueDepth)) begin
      add_word(id, wr, StFull);
    end else begin
      w.wr       = wr;
      w.id       = id;
      ring[tail] = w;
      tail       = IdxW'((int'(tail) + 1) % QueueDepth);
      count      = count + 1'b1;
    end
  endtask

  task automatic predict_grants(input logic [1:0] op, input logic [IdBits-1:0] id);
    res_t w;
    batch.delete();
    case (op)
      OpStartRead: request_start(id, 1'b0);
      OpStartWrite: request_start(id, 1'b1);
      OpEndRead: begin
        if (readers == 0) begin
          add_word(id, 1'b0, StNoHolder);
        end else begin
          readers = readers - 1'b1;
          if (readers == 0) serve_waiters();
        end
      end
      default: begin
        if (!writer) begin
          add_word(id, 1'b1, StNoHolder);
        end else begin
          writer = 1'b0;
          serve_waiters();
        end
      end
    endcase
    if (batch.size() > 0) begin
      w      = batch.pop_back();
      w.last = 1'b1;
      batch.push_back(w);
    end
    foreach (batch[i]) expected_grants.push_back(batch[i]);
  endtask

  task automatic check_word();
    res_t want;
    if (expected_grants.size() == 0) begin
      report_mismatch($sformatf("word with nothing expected: id=%0d write=%0b status=%0d",
                                grant_id_o, grant_write_o, status_o));
    end else begin
      want = expected_grants.pop_front();
      if (grant_id_o !== want.id || grant_write_o !== want.write ||
          status_o !== want.status || last_o !== want.last) begin
        report_mismatch($sformatf({"word %0d: got id=%0d write=%0b status=%0d last=%0b,",
                                   " want id=%0d write=%0b status=%0d last=%0b"},
                                  words_checked, grant_id_o, grant_write_o, status_o, last_o,
                                  want.id, want.write, want.status, want.last));
      end
      case (want.status)
        StGrant: grants_seen_o++;
        StFull: full_seen_o++;
        default: no_holder_seen_o++;
      endcase
    end
    words_checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head             = '0;
      tail             = '0;
      count            = '0;
      readers          = '0;
      writer           = 1'b0;
      words_checked    = 0;
      fail_count_o     = 0;
      grants_seen_o    = 0;
      full_seen_o      = 0;
      no_holder_seen_o = 0;
      expected_grants.delete();
      pending_o <= 0;
    end else begin
      if (push && !full) predict_grants(op_i, requester_id_i);
      if (pop && !empty) check_word();
      pending_o <= expected_grants.size();
    end
  end

endmodule

@@ tb/fifo_fair_reader_writer_arbiter_top_tb.sv @@
// Testbench top: drives lock requests and releases into the arbiter and gives the verdict.
module fifo_fair_reader_writer_arbiter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fffa_pkg::*;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              push           = 1'b0;
  logic [1:0]        op_i           = OpStartRead;
  logic [IdBits-1:0] requester_id_i = '0;
  logic              pop            = 1'b0;
  logic              full;
  logic              empty;
  logic [IdBits-1:0] grant_id_o;
  logic              grant_write_o;
  logic [1:0]        status_o;
  logic              last_o;

  int fail_count;
  int pending;
  int grants_seen;
  int full_seen;
  int no_holder_seen;
  int words_sent = 0;
  int directed_words;
  int pop_hold;
  bit calm = 1'b0;
  bit plan_q[$];

  fifo_fair_reader_writer_arbiter_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .requester_id_i (requester_id_i),
    .empty          (empty),
    .pop            (pop),
    .grant_id_o     (grant_id_o),
    .grant_write_o  (grant_write_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  fifo_fair_reader_writer_arbiter_checker grant_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .op_i             (op_i),
    .requester_id_i   (requester_id_i),
    .empty            (empty),
    .pop              (pop),
    .grant_id_o       (grant_id_o),
    .grant_write_o    (grant_write_o),
    .status_o         (status_o),
    .last_o           (last_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .grants_seen_o    (grants_seen),
    .full_seen_o      (full_seen),
    .no_holder_seen_o (no_holder_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IdBits-1:0] rand_id();
    return IdBits'($urandom_range(0, (1 << IdBits) - 1));
  endfunction

  initial begin
    forever begin
      repeat ($urandom_range(150, 400)) @(negedge clk_i);
      calm = ~calm;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if (!calm) pop_hold = pick_gap();
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [IdBits-1:0] id);
    int   gap;
    logic was_full;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    op_i           <= op;
    requester_id_i <= id;
    do begin
      @(negedge clk_i);
      was_full = full;
      @(posedge clk_i);
    end while (was_full);
    words_sent++;
  endtask

  // Take the lock, queue the planned requests behind the holder, then release
  // each holder group in the order in which the arbiter serves them.
  task automatic run_plan(input bit first_wr);
    bit queued[$];
    int idx;
    int n;
    send_word(first_wr ? OpStartWrite : OpStartRead, rand_id());
    foreach (plan_q[i]) begin
      send_word(plan_q[i] ? OpStartWrite : OpStartRead, rand_id());
      if (queued.size() < QueueDepth) queued.push_back(plan_q[i]);
    end
    send_word(first_wr ? OpEndWrite : OpEndRead, rand_id());
    idx = 0;
    while (idx < queued.size()) begin
      if (queued[idx]) begin
        send_word(OpEndWrite, rand_id());
        idx++;
      end else begin
        n = 0;
        while (idx < queued.size() && !queued[idx] && n < MaxResults) begin
          n++;
          idx++;
        end
        repeat (n) send_word(OpEndRead, rand_id());
      end
    end
  endtask

  // A few random words, then enough releases to bring the lock back to idle.
  task automatic run_noise();
    repeat ($urandom_range(1, 3)) send_word(2'($urandom_range(0, 3)), rand_id());
    repeat (4) begin
      repeat (3) send_word(OpEndRead, rand_id());
      send_word(OpEndWrite, rand_id());
    end
  endtask

  initial begin
    int ep;
    int n;
    int pct;
    int guard;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OpEndRead, '0);
    send_word(OpEndWrite, '1);
    plan_q.delete();
    run_plan(1'b1);
    plan_q = '{1'b1, 1'b0, 1'b0};
    run_plan(1'b0);
    directed_words = words_sent;

    ep = 0;
    while (words_sent < directed_words + 460) begin
      if (ep % 5 == 4) begin
        run_noise();
      end else begin
        plan_q.delete();
        if (ep % 8 == 3 || $urandom_range(0, 99) < 10) n = $urandom_range(15, 18);
        else n = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 75;
          2: pct = 50;
          default: pct = 0;
        endcase
        if (ep % 16 == 3) pct = 100;
        repeat (n) plan_q.push_back($urandom_range(0, 99) >= pct);
        run_plan($urandom_range(0, 1));
      end
      ep++;
    end
    push <= 1'b0;
    @(posedge clk_i);

    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);

    if (pending != 0) $display("%0d expected words never arrived", pending);
    $display("Sent %0d request words (%0d directed) in %0d random episodes.",
             words_sent, directed_words, ep);
    $display("Checked %0d grants, %0d full-queue rejections, %0d releases without holder.",
             grants_seen, full_seen, no_holder_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("** fifo_fair_reader_writer_arbiter_top: PASSED **");
    end else begin
      $display("** fifo_fair_reader_writer_arbiter_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Run timed out with %0d words still expected.", pending);
    $display("** fifo_fair_reader_writer_arbiter_top: FAILED **");
    $finish;
  end

endmodule
